// ===== rtl/lpdc_pkg.sv =====
// shared types, widths and constants of the lvdt pi dual coil driver
package lpdc_pkg;

  // configuration port
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 33;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_TICK_PERIOD = 3'd0,
    CFG_PROP_GAIN   = 3'd1,
    CFG_INTEG_GAIN  = 3'd2,
    CFG_INTEG_LIMIT = 3'd3,
    CFG_DRIVE_LIMIT = 3'd4
  } cfg_idx_e;

  // register and field widths
  localparam int unsigned TICK_W    = 16;
  localparam int unsigned PGAIN_W   = 16;
  localparam int unsigned IGAIN_W   = 18;
  localparam int unsigned ILIM_W    = 33;
  localparam int unsigned DLIM_W    = 17;
  localparam int unsigned POS_W     = 15;
  localparam int unsigned ERR_W     = 17;
  localparam int unsigned ERR_MAG_W = 16;
  localparam int unsigned INTEG_W   = 34;
  localparam int unsigned ISUM_W    = 35;
  localparam int unsigned TERM_W    = 24;
  localparam int unsigned PISUM_W   = 26;
  localparam int unsigned DRIVE_W   = 18;

  // register reset values
  localparam logic [TICK_W-1:0]  TICK_RST  = 16'd1000;
  localparam logic [PGAIN_W-1:0] PGAIN_RST = 16'd800;
  localparam logic [IGAIN_W-1:0] IGAIN_RST = 18'd50000;
  localparam logic [ILIM_W-1:0]  ILIM_RST  = 33'd2560000000;
  localparam logic [DLIM_W-1:0]  DLIM_RST  = 17'd40000;

  // serial multiplier: a is the parallel operand, b is consumed one bit a cycle
  localparam int unsigned MUL_A_W   = 33;
  localparam int unsigned MUL_B_W   = 18;
  localparam int unsigned MUL_P_W   = MUL_A_W + MUL_B_W;
  localparam int unsigned MUL_CNT_W = $clog2(MUL_B_W);

  // serial restoring divider: one quotient bit a cycle
  localparam int unsigned DIV_N_W   = 37;
  localparam int unsigned DIV_D_W   = 14;
  localparam int unsigned DIV_CNT_W = $clog2(DIV_N_W);

  // sensor window and scaling: pos = mv * 128 / 35 (same as mv * 25600 / 7000)
  localparam logic signed [15:0] MV_LOW_OK   = -16'sd500;
  localparam logic signed [15:0] MV_HIGH_OK  = 16'sd7500;
  localparam logic [POS_W-1:0]   POS_FULL    = 15'd25600;
  localparam logic [DIV_D_W-1:0] POS_DIVISOR = 14'd35;

  // integral term: product / 256000000 = (product >> 14) / 15625
  localparam int unsigned        I_PRE_SHIFT = 14;
  localparam logic [DIV_D_W-1:0] I_DIVISOR   = 14'd15625;

  // proportional term: product / 256
  localparam int unsigned P_SHIFT = 8;

  typedef enum logic [3:0] {
    ST_IDLE        = 4'd0,
    ST_POS_DIV     = 4'd1,
    ST_ERR         = 4'd2,
    ST_STEP_GO     = 4'd3,
    ST_STEP_MUL    = 4'd4,
    ST_INTEG_ADD   = 4'd5,
    ST_INTEG_CLAMP = 4'd6,
    ST_P_MUL       = 4'd7,
    ST_I_MUL       = 4'd8,
    ST_I_DIV       = 4'd9,
    ST_PI_SUM      = 4'd10,
    ST_DRIVE       = 4'd11,
    ST_OUT         = 4'd12
  } state_e;

endpackage

// ===== rtl/lpdc_chan_if.sv =====
// request and result channel interfaces of the lvdt pi dual coil driver
interface lpdc_in_if;
  logic                                  valid;
  logic                                  ready;
  logic signed [15:0]                    cmd_position;
  logic signed [15:0]                    lvdt_mv;
  logic                                  coil_a_failed;
  logic                                  coil_b_failed;

  modport source (
    output valid, cmd_position, lvdt_mv, coil_a_failed, coil_b_failed,
    input  ready
  );
  modport sink (
    input  valid, cmd_position, lvdt_mv, coil_a_failed, coil_b_failed,
    output ready
  );
endinterface

interface lpdc_out_if;
  logic                                  valid;
  logic                                  ready;
  logic signed [lpdc_pkg::DRIVE_W-1:0]   coil_drive_ua;
  logic signed [lpdc_pkg::DRIVE_W-1:0]   coil_a_ua;
  logic signed [lpdc_pkg::DRIVE_W-1:0]   coil_b_ua;
  logic        [lpdc_pkg::POS_W-1:0]     position_q8;
  logic                                  sensor_fault;

  modport source (
    output valid, coil_drive_ua, coil_a_ua, coil_b_ua, position_q8, sensor_fault,
    input  ready
  );
  modport sink (
    input  valid, coil_drive_ua, coil_a_ua, coil_b_ua, position_q8, sensor_fault,
    output ready
  );
endinterface

// ===== rtl/lvdt_pi_dual_coil_driver_core.sv =====
// lvdt position loop with pi control and dual coil current split, top level
//
// One request is one control tick: a position command, an lvdt sample in mV
// and the health of the two coils. A sample outside -500..7500 mV sets the
// sticky sensor fault and the last good position is reused; otherwise the
// sample is scaled to 0..25600 (percent in Q8) and clamped. The error feeds a
// pi law whose integrator is clamped to +/- integ_limit, the sum is clamped to
// +/- drive_limit_ua and split over the coils (halves, all to the healthy
// coil, or nothing). A new request is accepted only when the block is idle again,
// after the previous result has been loaded into the output register: the
// arithmetic runs one bit a cycle through a shared serial multiplier
// (three passes of 18 steps) and a shared serial divider (two passes of 37
// steps). A finished result sits in the output register while the next
// request is already being worked on. Registers may be written only while
// the block is idle.
module lvdt_pi_dual_coil_driver_core (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_we_i,
  input  logic [lpdc_pkg::CFG_IDX_W-1:0]    cfg_idx_i,
  input  logic [lpdc_pkg::CFG_DATA_W-1:0]   cfg_data_i,
  lpdc_in_if.sink                           in_i,
  lpdc_out_if.source                        out_o
);

  // configuration registers
  logic [lpdc_pkg::TICK_W-1:0]   tick_q;
  logic [lpdc_pkg::PGAIN_W-1:0]  pgain_q;
  logic [lpdc_pkg::IGAIN_W-1:0]  igain_q;
  logic [lpdc_pkg::ILIM_W-1:0]   ilim_q;
  logic [lpdc_pkg::DLIM_W-1:0]   dlim_q;

  // loop state kept across ticks
  logic signed [lpdc_pkg::INTEG_W-1:0] integ_q, integ_d;
  logic [lpdc_pkg::POS_W-1:0]          last_pos_q;
  logic                                fault_q;

  // per-request working registers
  lpdc_pkg::state_e                    state_q, state_d;
  logic signed [15:0]                  cmd_q;
  logic                                win_q;
  logic                                coil_a_fail_q;
  logic                                coil_b_fail_q;
  logic [lpdc_pkg::POS_W-1:0]          pos_q, pos_d;
  logic signed [lpdc_pkg::ERR_W-1:0]   err_q, err_d;
  logic signed [lpdc_pkg::ISUM_W-1:0]  isum_q, isum_d;
  logic [lpdc_pkg::TERM_W-1:0]         p_mag_q;
  logic [lpdc_pkg::TERM_W-1:0]         i_mag_q;
  logic signed [lpdc_pkg::PISUM_W-1:0] pisum_q, pisum_d;
  logic signed [lpdc_pkg::DRIVE_W-1:0] drive_q, drive_d;

  // result register
  logic                                out_valid_q;
  logic                                out_load;
  logic signed [lpdc_pkg::DRIVE_W-1:0] out_total_q, out_total_d;
  logic signed [lpdc_pkg::DRIVE_W-1:0] out_a_q, out_a_d;
  logic signed [lpdc_pkg::DRIVE_W-1:0] out_b_q, out_b_d;
  logic [lpdc_pkg::POS_W-1:0]          out_pos_q;
  logic                                out_fault_q;

  // serial units
  logic                                mul_start;
  logic [lpdc_pkg::MUL_A_W-1:0]        mul_a;
  logic [lpdc_pkg::MUL_B_W-1:0]        mul_b;
  logic                                mul_done;
  logic [lpdc_pkg::MUL_P_W-1:0]        mul_prod;
  logic                                div_start;
  logic [lpdc_pkg::DIV_N_W-1:0]        div_dividend;
  logic [lpdc_pkg::DIV_D_W-1:0]        div_divisor;
  logic                                div_done;
  logic [lpdc_pkg::DIV_N_W-1:0]        div_quo;

  // helper values
  logic                                in_accept;
  logic                                in_win;
  logic [lpdc_pkg::ERR_W-1:0]          err_abs;
  logic [lpdc_pkg::INTEG_W-1:0]        integ_abs;
  logic signed [lpdc_pkg::ISUM_W-1:0]  ilim_pos;
  logic signed [lpdc_pkg::ISUM_W-1:0]  ilim_neg;
  logic signed [lpdc_pkg::PISUM_W-1:0] p_term;
  logic signed [lpdc_pkg::PISUM_W-1:0] i_term;
  logic signed [lpdc_pkg::PISUM_W-1:0] dlim_pos;
  logic signed [lpdc_pkg::PISUM_W-1:0] dlim_neg;
  logic signed [lpdc_pkg::DRIVE_W-1:0] half_tmp;
  logic signed [lpdc_pkg::DRIVE_W-1:0] half;

  assign in_accept = in_i.valid && in_i.ready;
  assign in_i.ready = (state_q == lpdc_pkg::ST_IDLE);
  assign out_load = (state_q == lpdc_pkg::ST_OUT) && (!out_valid_q || out_o.ready);

  // sensor window, bounds included
  assign in_win = (in_i.lvdt_mv >= lpdc_pkg::MV_LOW_OK) &&
                  (in_i.lvdt_mv <= lpdc_pkg::MV_HIGH_OK);

  // magnitudes for the unsigned serial multiplier
  assign err_abs   = err_q[lpdc_pkg::ERR_W-1] ? (lpdc_pkg::ERR_W'(0) - err_q) : err_q;
  assign integ_abs = integ_q[lpdc_pkg::INTEG_W-1] ?
                     (lpdc_pkg::INTEG_W'(0) - integ_q) : integ_q;

  // sequencer
  always_comb begin
    state_d = state_q;
    case (state_q)
      lpdc_pkg::ST_IDLE:        if (in_i.valid) state_d = lpdc_pkg::ST_POS_DIV;
      lpdc_pkg::ST_POS_DIV:     if (div_done) state_d = lpdc_pkg::ST_ERR;
      lpdc_pkg::ST_ERR:         state_d = lpdc_pkg::ST_STEP_GO;
      lpdc_pkg::ST_STEP_GO:     state_d = lpdc_pkg::ST_STEP_MUL;
      lpdc_pkg::ST_STEP_MUL:    if (mul_done) state_d = lpdc_pkg::ST_INTEG_ADD;
      lpdc_pkg::ST_INTEG_ADD:   state_d = lpdc_pkg::ST_INTEG_CLAMP;
      lpdc_pkg::ST_INTEG_CLAMP: state_d = lpdc_pkg::ST_P_MUL;
      lpdc_pkg::ST_P_MUL:       if (mul_done) state_d = lpdc_pkg::ST_I_MUL;
      lpdc_pkg::ST_I_MUL:       if (mul_done) state_d = lpdc_pkg::ST_I_DIV;
      lpdc_pkg::ST_I_DIV:       if (div_done) state_d = lpdc_pkg::ST_PI_SUM;
      lpdc_pkg::ST_PI_SUM:      state_d = lpdc_pkg::ST_DRIVE;
      lpdc_pkg::ST_DRIVE:       state_d = lpdc_pkg::ST_OUT;
      lpdc_pkg::ST_OUT:         if (out_load) state_d = lpdc_pkg::ST_IDLE;
      default:                  state_d = lpdc_pkg::ST_IDLE;
    endcase
  end

  // units are launched on entry to their state, operands picked by that state
  always_comb begin
    mul_start = (state_d != state_q) &&
                ((state_d == lpdc_pkg::ST_STEP_MUL) ||
                 (state_d == lpdc_pkg::ST_P_MUL) ||
                 (state_d == lpdc_pkg::ST_I_MUL));
    div_start = (state_d != state_q) &&
                ((state_d == lpdc_pkg::ST_POS_DIV) || (state_d == lpdc_pkg::ST_I_DIV));

    case (state_d)
      lpdc_pkg::ST_I_MUL: begin
        mul_a = integ_abs[lpdc_pkg::MUL_A_W-1:0];
        mul_b = igain_q;
      end
      lpdc_pkg::ST_P_MUL: begin
        mul_a = lpdc_pkg::MUL_A_W'(err_abs[lpdc_pkg::ERR_MAG_W-1:0]);
        mul_b = lpdc_pkg::MUL_B_W'(pgain_q);
      end
      default: begin
        mul_a = lpdc_pkg::MUL_A_W'(err_abs[lpdc_pkg::ERR_MAG_W-1:0]);
        mul_b = lpdc_pkg::MUL_B_W'(tick_q);
      end
    endcase

    if (state_d == lpdc_pkg::ST_I_DIV) begin
      // i term magnitude: product >> 14, then / 15625
      div_dividend = mul_prod[lpdc_pkg::MUL_P_W-1:lpdc_pkg::I_PRE_SHIFT];
      div_divisor  = lpdc_pkg::I_DIVISOR;
    end else begin
      // position: mv * 128 / 35, a negative sample gives zero
      div_dividend = in_i.lvdt_mv[15] ? '0 :
                     lpdc_pkg::DIV_N_W'({in_i.lvdt_mv[14:0], 7'd0});
      div_divisor  = lpdc_pkg::POS_DIVISOR;
    end
  end

  // datapath next values
  always_comb begin
    // position: saturate at full travel, or hold the last good one on a fault
    if (!win_q) begin
      pos_d = last_pos_q;
    end else if (div_quo > lpdc_pkg::DIV_N_W'(lpdc_pkg::POS_FULL)) begin
      pos_d = lpdc_pkg::POS_FULL;
    end else begin
      pos_d = div_quo[lpdc_pkg::POS_W-1:0];
    end

    err_d = {cmd_q[15], cmd_q} - lpdc_pkg::ERR_W'(pos_q);

    // integrator advance by error * tick period
    if (err_q[lpdc_pkg::ERR_W-1]) begin
      isum_d = {integ_q[lpdc_pkg::INTEG_W-1], integ_q} - lpdc_pkg::ISUM_W'(mul_prod[31:0]);
    end else begin
      isum_d = {integ_q[lpdc_pkg::INTEG_W-1], integ_q} + lpdc_pkg::ISUM_W'(mul_prod[31:0]);
    end

    ilim_pos = lpdc_pkg::ISUM_W'(ilim_q);
    ilim_neg = lpdc_pkg::ISUM_W'(0) - ilim_pos;
    if (isum_q > ilim_pos) begin
      integ_d = ilim_pos[lpdc_pkg::INTEG_W-1:0];
    end else if (isum_q < ilim_neg) begin
      integ_d = ilim_neg[lpdc_pkg::INTEG_W-1:0];
    end else begin
      integ_d = isum_q[lpdc_pkg::INTEG_W-1:0];
    end

    // signed p and i terms, both truncated toward zero via their magnitudes
    p_term = err_q[lpdc_pkg::ERR_W-1] ?
             (lpdc_pkg::PISUM_W'(0) - lpdc_pkg::PISUM_W'(p_mag_q)) :
             lpdc_pkg::PISUM_W'(p_mag_q);
    i_term = integ_q[lpdc_pkg::INTEG_W-1] ?
             (lpdc_pkg::PISUM_W'(0) - lpdc_pkg::PISUM_W'(i_mag_q)) :
             lpdc_pkg::PISUM_W'(i_mag_q);
    pisum_d = p_term + i_term;

    dlim_pos = lpdc_pkg::PISUM_W'(dlim_q);
    dlim_neg = lpdc_pkg::PISUM_W'(0) - dlim_pos;
    if (pisum_q > dlim_pos) begin
      drive_d = dlim_pos[lpdc_pkg::DRIVE_W-1:0];
    end else if (pisum_q < dlim_neg) begin
      drive_d = dlim_neg[lpdc_pkg::DRIVE_W-1:0];
    end else begin
      drive_d = pisum_q[lpdc_pkg::DRIVE_W-1:0];
    end

    // half of the drive, truncated toward zero
    half_tmp = drive_q + lpdc_pkg::DRIVE_W'(drive_q[lpdc_pkg::DRIVE_W-1]);
    half     = {half_tmp[lpdc_pkg::DRIVE_W-1], half_tmp[lpdc_pkg::DRIVE_W-1:1]};

    // coil allocation by health
    if (coil_a_fail_q && coil_b_fail_q) begin
      out_total_d = '0;
      out_a_d     = '0;
      out_b_d     = '0;
    end else if (coil_a_fail_q) begin
      out_total_d = drive_q;
      out_a_d     = '0;
      out_b_d     = drive_q;
    end else if (coil_b_fail_q) begin
      out_total_d = drive_q;
      out_a_d     = drive_q;
      out_b_d     = '0;
    end else begin
      out_total_d = drive_q;
      out_a_d     = half;
      out_b_d     = half;
    end
  end

  // control state, configuration and loop state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= lpdc_pkg::ST_IDLE;
      tick_q      <= lpdc_pkg::TICK_RST;
      pgain_q     <= lpdc_pkg::PGAIN_RST;
      igain_q     <= lpdc_pkg::IGAIN_RST;
      ilim_q      <= lpdc_pkg::ILIM_RST;
      dlim_q      <= lpdc_pkg::DLIM_RST;
      integ_q     <= '0;
      last_pos_q  <= '0;
      fault_q     <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;

      if (cfg_we_i) begin
        case (lpdc_pkg::cfg_idx_e'(cfg_idx_i))
          lpdc_pkg::CFG_TICK_PERIOD: tick_q  <= cfg_data_i[lpdc_pkg::TICK_W-1:0];
          lpdc_pkg::CFG_PROP_GAIN:   pgain_q <= cfg_data_i[lpdc_pkg::PGAIN_W-1:0];
          lpdc_pkg::CFG_INTEG_GAIN:  igain_q <= cfg_data_i[lpdc_pkg::IGAIN_W-1:0];
          lpdc_pkg::CFG_INTEG_LIMIT: ilim_q  <= cfg_data_i[lpdc_pkg::ILIM_W-1:0];
          lpdc_pkg::CFG_DRIVE_LIMIT: dlim_q  <= cfg_data_i[lpdc_pkg::DLIM_W-1:0];
          default: ;
        endcase
      end

      // sticky fault on an out-of-window sample
      if (in_accept && !in_win) begin
        fault_q <= 1'b1;
      end

      if ((state_q == lpdc_pkg::ST_POS_DIV) && div_done && win_q) begin
        last_pos_q <= pos_d;
      end

      if (state_q == lpdc_pkg::ST_INTEG_CLAMP) begin
        integ_q <= integ_d;
      end

      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      cmd_q         <= in_i.cmd_position;
      win_q         <= in_win;
      coil_a_fail_q <= in_i.coil_a_failed;
      coil_b_fail_q <= in_i.coil_b_failed;
    end
    if ((state_q == lpdc_pkg::ST_POS_DIV) && div_done) begin
      pos_q <= pos_d;
    end
    if (state_q == lpdc_pkg::ST_ERR) begin
      err_q <= err_d;
    end
    if (state_q == lpdc_pkg::ST_INTEG_ADD) begin
      isum_q <= isum_d;
    end
    if ((state_q == lpdc_pkg::ST_P_MUL) && mul_done) begin
      p_mag_q <= mul_prod[lpdc_pkg::P_SHIFT +: lpdc_pkg::TERM_W];
    end
    if ((state_q == lpdc_pkg::ST_I_DIV) && div_done) begin
      i_mag_q <= div_quo[lpdc_pkg::TERM_W-1:0];
    end
    if (state_q == lpdc_pkg::ST_PI_SUM) begin
      pisum_q <= pisum_d;
    end
    if (state_q == lpdc_pkg::ST_DRIVE) begin
      drive_q <= drive_d;
    end
    if (out_load) begin
      out_total_q <= out_total_d;
      out_a_q     <= out_a_d;
      out_b_q     <= out_b_d;
      out_pos_q   <= pos_q;
      out_fault_q <= fault_q;
    end
  end

  lpdc_ser_mul u_mul (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (mul_start),
    .a_i     (mul_a),
    .b_i     (mul_b),
    .done_o  (mul_done),
    .prod_o  (mul_prod)
  );

  lpdc_ser_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (div_dividend),
    .divisor_i  (div_divisor),
    .done_o     (div_done),
    .quo_o      (div_quo)
  );

  assign out_o.valid         = out_valid_q;
  assign out_o.coil_drive_ua = out_total_q;
  assign out_o.coil_a_ua     = out_a_q;
  assign out_o.coil_b_ua     = out_b_q;
  assign out_o.position_q8   = out_pos_q;
  assign out_o.sensor_fault  = out_fault_q;

endmodule

// ===== rtl/lpdc_ser_mul.sv =====
// bit-serial unsigned shift-add multiplier, one multiplier bit per cycle
module lpdc_ser_mul (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              start_i,
  input  logic [lpdc_pkg::MUL_A_W-1:0]      a_i,
  input  logic [lpdc_pkg::MUL_B_W-1:0]      b_i,
  output logic                              done_o,
  output logic [lpdc_pkg::MUL_P_W-1:0]      prod_o
);

  logic [lpdc_pkg::MUL_A_W-1:0]   a_q;
  logic [lpdc_pkg::MUL_A_W-1:0]   hi_q, hi_d;
  logic [lpdc_pkg::MUL_B_W-1:0]   lo_q, lo_d;
  logic [lpdc_pkg::MUL_A_W:0]     add;
  logic [lpdc_pkg::MUL_CNT_W-1:0] cnt_q;
  logic                           busy_q;
  logic                           done_q;

  // partial sum for the current multiplier bit, then shift right
  always_comb begin
    add  = {1'b0, hi_q} + (lo_q[0] ? {1'b0, a_q} : '0);
    hi_d = add[lpdc_pkg::MUL_A_W:1];
    lo_d = {add[0], lo_q[lpdc_pkg::MUL_B_W-1:1]};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        if (cnt_q == lpdc_pkg::MUL_CNT_W'(lpdc_pkg::MUL_B_W - 1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end else begin
          cnt_q <= cnt_q + 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      a_q  <= a_i;
      hi_q <= '0;
      lo_q <= b_i;
    end else if (busy_q) begin
      hi_q <= hi_d;
      lo_q <= lo_d;
    end
  end

  assign done_o = done_q;
  assign prod_o = {hi_q, lo_q};

endmodule

// ===== rtl/lpdc_ser_div.sv =====
// bit-serial restoring divider, one quotient bit per cycle
module lpdc_ser_div (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              start_i,
  input  logic [lpdc_pkg::DIV_N_W-1:0]      dividend_i,
  input  logic [lpdc_pkg::DIV_D_W-1:0]      divisor_i,
  output logic                              done_o,
  output logic [lpdc_pkg::DIV_N_W-1:0]      quo_o
);

  logic [lpdc_pkg::DIV_N_W-1:0]   quo_q, quo_d;
  logic [lpdc_pkg::DIV_D_W-1:0]   rem_q, rem_d;
  logic [lpdc_pkg::DIV_D_W-1:0]   dvs_q;
  logic [lpdc_pkg::DIV_D_W:0]     trial;
  logic [lpdc_pkg::DIV_D_W:0]     diff;
  logic                           fits;
  logic [lpdc_pkg::DIV_CNT_W-1:0] cnt_q;
  logic                           busy_q;
  logic                           done_q;

  // bring down the next dividend bit, subtract when the divisor fits
  always_comb begin
    trial = {rem_q, quo_q[lpdc_pkg::DIV_N_W-1]};
    diff  = trial - {1'b0, dvs_q};
    fits  = (trial >= {1'b0, dvs_q});
    rem_d = fits ? diff[lpdc_pkg::DIV_D_W-1:0] : trial[lpdc_pkg::DIV_D_W-1:0];
    quo_d = {quo_q[lpdc_pkg::DIV_N_W-2:0], fits};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        if (cnt_q == lpdc_pkg::DIV_CNT_W'(lpdc_pkg::DIV_N_W - 1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end else begin
          cnt_q <= cnt_q + 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      quo_q <= dividend_i;
      rem_q <= '0;
      dvs_q <= divisor_i;
    end else if (busy_q) begin
      quo_q <= quo_d;
      rem_q <= rem_d;
    end
  end

  assign done_o = done_q;
  assign quo_o  = quo_q;

endmodule
